// File: design/c32nh_pkg.sv
// Package for the CRC-32 name hash stream: data types, the polynomial
// and the constant lookup table built at elaboration.
// No dependencies.
`default_nettype none
package c32nh_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_crc;
    typedef t_crc        t_table [256];

    localparam t_crc  CRC_POLY  = 32'h04C1_1DB7;
    localparam t_byte NAME_TERM = 8'h00;

    // Entry for one seed: shift the seed from the top byte eight times and
    // fold in the polynomial only when the top bit was clear.
    function automatic t_crc f_seed_entry(input t_byte seed);
        t_crc v;
        v = {seed, 24'h00_0000};
        for (int n = 0; n < 8; n++) begin
            if (v[31]) begin
                v = {v[30:0], 1'b0};
            end else begin
                v = {v[30:0], 1'b0} ^ CRC_POLY;
            end
        end
        return v;
    endfunction

    // Entries are stored in reverse order: entry k belongs to seed 255 - k.
    function automatic t_table f_build_table();
        t_table tbl;
        for (int k = 0; k < 256; k++) begin
            tbl[k] = f_seed_entry(~t_byte'(k));
        end
        return tbl;
    endfunction

    localparam t_table CRC_TABLE = f_build_table();
    localparam t_crc   CRC_INIT  = CRC_TABLE[0];

endpackage
`default_nettype wire

// File: design/c32nh_byte_if.sv
// Channel interface for incoming name bytes: valid, ready and one byte.
// No dependencies.
`default_nettype none
interface c32nh_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

// File: design/c32nh_crc_if.sv
// Channel interface for finished name checksums: valid, ready and 32 bits.
// No dependencies.
`default_nettype none
interface c32nh_crc_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;

    modport source (output valid, output crc_value, input ready);
    modport sink   (input valid, input crc_value, output ready);
endinterface
`default_nettype wire

// File: design/c32nh_update.sv
// One byte step of the MSB-first CRC: a table lookup and an XOR.
// Depends on c32nh_pkg for the types and the lookup table.
`default_nettype none
module c32nh_update (
    input  wire  c32nh_pkg::t_crc  i_crc,
    input  wire  c32nh_pkg::t_byte i_byte,
    output       c32nh_pkg::t_crc  o_crc
);
    import c32nh_pkg::*;

    t_byte w_index;

    // The top byte of the running value meets the new byte to pick an entry.
    assign w_index = i_byte ^ i_crc[31:24];
    assign o_crc   = CRC_TABLE[w_index] ^ {i_crc[23:0], 8'h00};

endmodule
`default_nettype wire

// File: design/crc32_name_hash_stream.sv
// Top level of the CRC-32 name hash stream.
// Depends on c32nh_pkg, c32nh_byte_if, c32nh_crc_if and c32nh_update.
//
// Usage:
//   i_byte carries the characters of a name, one item per byte. A zero byte
//   ends the name; it is folded into the CRC like any other byte. o_crc then
//   carries one item, the 32-bit checksum of the name including the zero.
//   Non-zero bytes give no output item.
// Throughput and timing:
//   One byte is taken every cycle while no stall holds the input. A byte
//   sits in the input register, where the table lookup and XOR update the
//   running value; a checksum appears on o_crc in the cycle after the
//   terminator leaves the input register. The running-value feedback
//   through the single table lookup sets the one-byte-per-cycle figure.
// Reset:
//   i_rst_n is synchronous and active low. It empties both registers and
//   sets the running value to its start value, table entry zero.
// Stalls:
//   While a checksum waits on o_crc, bytes of the next name keep flowing.
//   Only a second terminator that reaches the input register before the
//   waiting checksum is taken holds back i_byte.ready.
`default_nettype none
module crc32_name_hash_stream (
    input  wire            i_clk,
    input  wire            i_rst_n,
    c32nh_byte_if.sink     i_byte,
    c32nh_crc_if.source    o_crc
);
    import c32nh_pkg::*;

    logic  r_s1_valid, n_s1_valid;
    t_byte r_s1_byte;
    t_crc  r_crc, n_crc;
    logic  r_out_valid, n_out_valid;
    t_crc  r_out_crc;

    t_crc  w_step;
    logic  w_term;
    logic  w_out_free;
    logic  w_s1_go;
    logic  w_s1_fire;
    logic  w_out_load;

    // Byte step on the registered input.
    c32nh_update u_update (
        .i_crc  (r_crc),
        .i_byte (r_s1_byte),
        .o_crc  (w_step)
    );

    // Flow control: the input register only waits when a terminator has
    // no free slot in the result register.
    assign w_term      = (r_s1_byte == NAME_TERM);
    assign w_out_free  = !r_out_valid || o_crc.ready;
    assign w_s1_go     = !w_term || w_out_free;
    assign w_s1_fire   = r_s1_valid && w_s1_go;
    assign w_out_load  = w_s1_fire && w_term;
    assign i_byte.ready = !r_s1_valid || w_s1_go;

    // Next values of the control and running state.
    always_comb begin
        n_s1_valid  = i_byte.valid || (r_s1_valid && !w_s1_go);
        n_out_valid = w_out_load || (r_out_valid && !o_crc.ready);
        n_crc       = r_crc;
        if (w_s1_fire) begin
            n_crc = w_term ? CRC_INIT : w_step;
        end
    end

    // Control registers and the running value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
            r_crc       <= n_crc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_byte.ready) begin
            r_s1_byte <= i_byte.data_byte;
        end
        if (w_out_load) begin
            r_out_crc <= w_step;
        end
    end

    assign o_crc.valid     = r_out_valid;
    assign o_crc.crc_value = r_out_crc;

    // A terminator leaves the running value at its start value.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_crc == CRC_INIT))
        else $error("running value not restarted after terminator");

    // A terminator delivers the folded value as the next result.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && r_out_crc == $past(w_step)))
        else $error("checksum not captured after terminator");

    // A non-terminator byte advances the running value by one step.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s1_fire && !w_term) |=> (r_crc == $past(w_step)))
        else $error("running value not advanced by byte step");

    // Input is held back only by a terminator facing a blocked result.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_byte.ready |-> (r_s1_valid && w_term && r_out_valid && !o_crc.ready))
        else $error("input stalled without a blocked terminator");

endmodule
`default_nettype wire
